### src/alc_pkg.sv
package alc_pkg;

  // Port width of every intensity, alpha and result field
  localparam int FIELD_W = 17;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONTRIB,
    ST_RED,
    ST_GREEN,
    ST_BLUE,
    ST_TRANS,
    ST_FIN
  } alc_state_t;

  // Operand pair fed to the shared multiplier
  typedef enum logic [2:0] {
    MS_CONTRIB,
    MS_RED,
    MS_GREEN,
    MS_BLUE,
    MS_TRANS
  } alc_msel_t;

  // Accumulator that takes the registered product this cycle
  typedef enum logic [1:0] {
    ACC_NONE,
    ACC_RED,
    ACC_GREEN,
    ACC_BLUE
  } alc_acc_t;

  typedef struct packed {
    logic      in_ready;
    alc_msel_t mul_sel;
    logic      load_contrib;
    alc_acc_t  acc_sel;
    logic      load_trans;
    logic      emit;
  } alc_ctl_t;

  typedef struct packed {
    logic in_valid;
    logic in_covers;
    logic item_covers;
    logic item_last;
    logic out_free;
  } alc_sts_t;

endpackage

### src/alc_in_if.sv
interface alc_in_if;
  import alc_pkg::*;

  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] red_in;
  logic [FIELD_W-1:0] green_in;
  logic [FIELD_W-1:0] blue_in;
  logic [FIELD_W-1:0] alpha_in;
  logic [1:0]         channel_count;
  logic               covers_pixel;
  logic               alpha_present;
  logic               last_layer;

  modport source (
    output valid, red_in, green_in, blue_in, alpha_in,
           channel_count, covers_pixel, alpha_present, last_layer,
    input  ready
  );

  modport sink (
    input  valid, red_in, green_in, blue_in, alpha_in,
           channel_count, covers_pixel, alpha_present, last_layer,
    output ready
  );

endinterface

### src/alc_out_if.sv
interface alc_out_if;
  import alc_pkg::*;

  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] red_out;
  logic [FIELD_W-1:0] green_out;
  logic [FIELD_W-1:0] blue_out;

  modport source (
    output valid, red_out, green_out, blue_out,
    input  ready
  );

  modport sink (
    input  valid, red_out, green_out, blue_out,
    output ready
  );

endinterface

### src/alc_mul.sv
module alc_mul #(
  parameter int FRACTION_BITS = 16
) (
  input  logic [FRACTION_BITS:0] a,
  input  logic [FRACTION_BITS:0] b,
  output logic [FRACTION_BITS:0] p
);
  import alc_pkg::*;

  localparam int VW = FRACTION_BITS + 1;

  logic [2*VW-1:0] full;

  // Truncating fixed-point product; operands never exceed 1.0
  assign full = a * b;
  assign p    = full[FRACTION_BITS +: VW];

endmodule

### src/alc_ctrl.sv
module alc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  alc_pkg::alc_sts_t sts,
  output alc_pkg::alc_ctl_t ctl
);
  import alc_pkg::*;

  alc_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt        = state_r;
    ctl.in_ready     = 1'b0;
    ctl.mul_sel      = MS_CONTRIB;
    ctl.load_contrib = 1'b0;
    ctl.acc_sel      = ACC_NONE;
    ctl.load_trans   = 1'b0;
    ctl.emit         = 1'b0;
    case (state_r)
      ST_IDLE: begin
        ctl.in_ready = 1'b1;
        if (sts.in_valid) begin
          state_nxt = sts.in_covers ? ST_CONTRIB : ST_FIN;
        end
      end
      ST_CONTRIB: begin
        ctl.mul_sel = MS_CONTRIB;
        state_nxt   = ST_RED;
      end
      ST_RED: begin
        ctl.mul_sel      = MS_RED;
        ctl.load_contrib = 1'b1;
        state_nxt        = ST_GREEN;
      end
      ST_GREEN: begin
        ctl.mul_sel = MS_GREEN;
        ctl.acc_sel = ACC_RED;
        state_nxt   = ST_BLUE;
      end
      ST_BLUE: begin
        ctl.mul_sel = MS_BLUE;
        ctl.acc_sel = ACC_GREEN;
        state_nxt   = ST_TRANS;
      end
      ST_TRANS: begin
        ctl.mul_sel = MS_TRANS;
        ctl.acc_sel = ACC_BLUE;
        state_nxt   = ST_FIN;
      end
      ST_FIN: begin
        if (!sts.item_last) begin
          ctl.load_trans = sts.item_covers;
          state_nxt      = ST_IDLE;
        end else if (sts.out_free) begin
          ctl.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### src/alpha_layer_compositor_top.sv
// Channel  Dir  Transfer                 Payload
// in_ch    in   valid & ready at clk     red/green/blue/alpha_in (17b), channel_count (2b),
//                                        covers_pixel, alpha_present, last_layer
// out_ch   out  valid & ready at clk     red_out, green_out, blue_out (17b)
//
// A covering layer sends five products one after another through the single shared
// multiplier, then a finish step. A layer that does not cover the pixel goes straight
// to the finish step.
// Reset (rst_n low, synchronous) sets transmittance to 1.0 and the sums to 0.
// The result sits in an output register; in_ch is taken again while it waits.
// Only a last layer meeting a still-full output register stalls in the finish step.
module alpha_layer_compositor_top #(
  parameter int FRACTION_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  alc_in_if.sink    in_ch,
  alc_out_if.source out_ch
);
  import alc_pkg::*;

  localparam int VW = FRACTION_BITS + 1;
  // Compare width for clamping port fields against 1.0
  localparam int CW = (FIELD_W > VW) ? FIELD_W : VW;
  localparam logic [VW-1:0] ONE = {1'b1, {FRACTION_BITS{1'b0}}};

  alc_ctl_t ctl;
  alc_sts_t sts;

  logic in_xfer;

  // Latched layer sample, already clamped and with channel fallback applied
  logic [VW-1:0] r_r, g_r, b_r, a_r, oma_r;
  logic          cov_r, last_r;

  // Pixel state
  logic [VW-1:0] trans_r, red_sum_r, green_sum_r, blue_sum_r;

  // Shared multiplier and its output registers
  logic [VW-1:0] mul_a, mul_b, mul_p;
  logic [VW-1:0] prod_r, contrib_r;

  // Accumulate path
  logic [VW-1:0] acc_cur, acc_nxt;
  logic [VW:0]   acc_sum;

  // Output register
  logic               out_valid_r;
  logic [FIELD_W-1:0] red_out_r, green_out_r, blue_out_r;

  // Clamped inputs
  logic [VW-1:0] red_c, green_c, blue_c, alpha_c, alpha_eff;

  function automatic logic [VW-1:0] clamp_field(input logic [FIELD_W-1:0] x);
    logic [CW-1:0] ext;
    ext = CW'(x);
    return (ext > CW'(ONE)) ? ONE : ext[VW-1:0];
  endfunction

  assign red_c     = clamp_field(in_ch.red_in);
  assign green_c   = clamp_field(in_ch.green_in);
  assign blue_c    = clamp_field(in_ch.blue_in);
  assign alpha_c   = clamp_field(in_ch.alpha_in);
  assign alpha_eff = in_ch.alpha_present ? alpha_c : ONE;

  // No transfer while reset is held
  assign in_ch.ready = ctl.in_ready && rst_n;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  assign sts.in_valid    = in_ch.valid;
  assign sts.in_covers   = in_ch.covers_pixel;
  assign sts.item_covers = cov_r;
  assign sts.item_last   = last_r;
  assign sts.out_free    = !out_valid_r || out_ch.ready;

  alc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .ctl   (ctl)
  );

  // Capture the sample; one channel feeds all three colors, two channels
  // reuse green for blue, zero channels act as one.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      r_r    <= red_c;
      a_r    <= alpha_eff;
      oma_r  <= ONE - alpha_eff;
      cov_r  <= in_ch.covers_pixel;
      last_r <= in_ch.last_layer;
      case (in_ch.channel_count)
        2'd2: begin
          g_r <= green_c;
          b_r <= green_c;
        end
        2'd3: begin
          g_r <= green_c;
          b_r <= blue_c;
        end
        default: begin
          g_r <= red_c;
          b_r <= red_c;
        end
      endcase
    end
  end

  // Operand select: contrib = alpha*T, then each color times contrib,
  // last T*(1-alpha) while T still holds its old value.
  always_comb begin
    case (ctl.mul_sel)
      MS_CONTRIB: begin
        mul_a = a_r;
        mul_b = trans_r;
      end
      MS_RED: begin
        mul_a = r_r;
        mul_b = prod_r;
      end
      MS_GREEN: begin
        mul_a = g_r;
        mul_b = contrib_r;
      end
      MS_BLUE: begin
        mul_a = b_r;
        mul_b = contrib_r;
      end
      MS_TRANS: begin
        mul_a = trans_r;
        mul_b = oma_r;
      end
      default: begin
        mul_a = a_r;
        mul_b = trans_r;
      end
    endcase
  end

  alc_mul #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_mul (
    .a (mul_a),
    .b (mul_b),
    .p (mul_p)
  );

  always_ff @(posedge clk) begin
    prod_r <= mul_p;
    if (ctl.load_contrib) begin
      contrib_r <= prod_r;
    end
  end

  // Saturating add of the registered product into the selected sum
  always_comb begin
    case (ctl.acc_sel)
      ACC_RED:   acc_cur = red_sum_r;
      ACC_GREEN: acc_cur = green_sum_r;
      ACC_BLUE:  acc_cur = blue_sum_r;
      default:   acc_cur = red_sum_r;
    endcase
    acc_sum = {1'b0, acc_cur} + {1'b0, prod_r};
    acc_nxt = (acc_sum > {1'b0, ONE}) ? ONE : acc_sum[VW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trans_r     <= ONE;
      red_sum_r   <= '0;
      green_sum_r <= '0;
      blue_sum_r  <= '0;
    end else if (ctl.emit) begin
      trans_r     <= ONE;
      red_sum_r   <= '0;
      green_sum_r <= '0;
      blue_sum_r  <= '0;
    end else begin
      if (ctl.load_trans) begin
        trans_r <= prod_r;
      end
      case (ctl.acc_sel)
        ACC_RED:   red_sum_r   <= acc_nxt;
        ACC_GREEN: green_sum_r <= acc_nxt;
        ACC_BLUE:  blue_sum_r  <= acc_nxt;
        default: begin
        end
      endcase
    end
  end

  // Sums are kept at or below 1.0, so the result is just resized
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      red_out_r   <= FIELD_W'(red_sum_r);
      green_out_r <= FIELD_W'(green_sum_r);
      blue_out_r  <= FIELD_W'(blue_sum_r);
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.red_out   = red_out_r;
  assign out_ch.green_out = green_out_r;
  assign out_ch.blue_out  = blue_out_r;

  // One layer at a time: no back-to-back input transfers
  a_no_b2b_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_ch.ready)
    else $error("input taken while a layer is in flight");

  // An emit never overwrites a result that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.emit |-> (!out_valid_r || out_ch.ready))
    else $error("result overwritten");

  // Emit always presents a result on the next cycle, with state back at reset
  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.emit |=> (out_ch.valid && trans_r == ONE && red_sum_r == '0))
    else $error("emit did not present result or clear state");

  // Transmittance and sums never pass 1.0
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    (trans_r <= ONE) && (red_sum_r <= ONE) && (green_sum_r <= ONE)
      && (blue_sum_r <= ONE))
    else $error("pixel state above 1.0");

endmodule

### test/alpha_layer_compositor_top_tb.sv
`timescale 1ns / 1ps

module alpha_layer_compositor_top_tb;
  import alc_pkg::*;

  localparam int FRAC = 16;
  localparam logic [FIELD_W-1:0] UNITY = FIELD_W'(1 << FRAC);
  // Hang guard; this leaves lots of margin over the slowest run
  localparam int CYCLE_LIMIT = 200000;
  localparam int ITEM_TARGET = 1050;

  // One layer sample as seen on in_ch
  typedef struct {
    logic [FIELD_W-1:0] red;
    logic [FIELD_W-1:0] green;
    logic [FIELD_W-1:0] blue;
    logic [FIELD_W-1:0] alpha;
    logic [1:0]         chans;
    logic               covers;
    logic               alpha_ok;
    logic               last;
  } layer_t;

  // One composited pixel as seen on out_ch
  typedef struct {
    logic [FIELD_W-1:0] red;
    logic [FIELD_W-1:0] green;
    logic [FIELD_W-1:0] blue;
  } pixel_t;

  // Front-to-back blend predictor plus the queue of pixels still owed by the DUT
  class blend_scoreboard;
    logic [FIELD_W-1:0] trans;
    logic [FIELD_W-1:0] sum_r;
    logic [FIELD_W-1:0] sum_g;
    logic [FIELD_W-1:0] sum_b;
    pixel_t expected_pixels[$];
    int errors;
    int shown;

    function new();
      clear();
      errors = 0;
      shown  = 0;
    endfunction

    function void clear();
      trans = UNITY;
      sum_r = '0;
      sum_g = '0;
      sum_b = '0;
    endfunction

    function logic [FIELD_W-1:0] limit1(logic [FIELD_W:0] v);
      return (v > UNITY) ? UNITY : v[FIELD_W-1:0];
    endfunction

    // Truncating Q1.16 multiply; both operands are at most 1.0
    function logic [FIELD_W-1:0] qmul(logic [FIELD_W-1:0] a, logic [FIELD_W-1:0] b);
      logic [2*FIELD_W-1:0] p;
      p = a * b;
      return p[FRAC+FIELD_W-1:FRAC];
    endfunction

    function void note_layer(layer_t l);
      logic [FIELD_W-1:0] r, g, b, a, gv, bv, weight;
      r = limit1({1'b0, l.red});
      g = limit1({1'b0, l.green});
      b = limit1({1'b0, l.blue});
      a = limit1({1'b0, l.alpha});
      if (l.covers) begin
        if (!l.alpha_ok) a = UNITY;
        case (l.chans)
          2'd0, 2'd1: begin
            gv = r;
            bv = r;
          end
          2'd2: begin
            gv = g;
            bv = g;
          end
          default: begin
            gv = g;
            bv = b;
          end
        endcase
        weight = qmul(a, trans);
        sum_r  = limit1({1'b0, sum_r} + qmul(r, weight));
        sum_g  = limit1({1'b0, sum_g} + qmul(gv, weight));
        sum_b  = limit1({1'b0, sum_b} + qmul(bv, weight));
        trans  = qmul(trans, UNITY - a);
      end
      if (l.last) begin
        expected_pixels = {expected_pixels, pixel_t'{sum_r, sum_g, sum_b}};
        clear();
      end
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (expected_pixels.size() == 0) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("unexpected pixel r=%h g=%h b=%h", got.red, got.green, got.blue);
        end
        return;
      end
      want = expected_pixels.pop_front();
      if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("pixel mismatch: expected r=%h g=%h b=%h, got r=%h g=%h b=%h",
                   want.red, want.green, want.blue, got.red, got.green, got.blue);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int   cycles = 0;
  int   items_sent = 0;
  int   send_quiet = 0;
  int   recv_quiet = 0;
  blend_scoreboard board;

  alc_in_if  in_ch();
  alc_out_if out_ch();

  alpha_layer_compositor_top #(.FRACTION_BITS(FRAC)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Hard stop in case the DUT hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("alpha_layer_compositor_top_tb failed");
      $finish;
    end
  end

  // Monitor: result check first, then predict from the input transfer.
  // A result at this edge can only come from a layer taken at an earlier edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready)
        board.check_pixel(pixel_t'{out_ch.red_out, out_ch.green_out, out_ch.blue_out});
      if (in_ch.valid && in_ch.ready)
        board.note_layer(layer_t'{in_ch.red_in, in_ch.green_in, in_ch.blue_in,
                                  in_ch.alpha_in, in_ch.channel_count, in_ch.covers_pixel,
                                  in_ch.alpha_present, in_ch.last_layer});
    end
  end

  // Idle draw 0..15, with occasional stretches of zero idle
  function automatic int draw_wait(inout int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) quiet = $urandom_range(10, 40);
    return $urandom_range(0, 15);
  endfunction

  // Intensity/alpha value biased toward the edges, including over-range codes
  function automatic logic [FIELD_W-1:0] draw_level();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return UNITY;
      2:       return '1;
      3:       return FIELD_W'($urandom_range(UNITY + 1, 2**FIELD_W - 1));
      4:       return FIELD_W'($urandom_range(0, 255));
      5:       return UNITY - FIELD_W'($urandom_range(1, 255));
      default: return FIELD_W'($urandom_range(0, UNITY));
    endcase
  endfunction

  // Offer one layer after a random gap, return once it has been transferred.
  // valid stays high across back-to-back items, so it gets one NBA per edge.
  task automatic send_layer(input logic [FIELD_W-1:0] r, input logic [FIELD_W-1:0] g,
                            input logic [FIELD_W-1:0] b, input logic [FIELD_W-1:0] a,
                            input logic [1:0] ch, input logic cov, input logic ap,
                            input logic last);
    int gap;
    gap = draw_wait(send_quiet);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.red_in        <= r;
    in_ch.green_in      <= g;
    in_ch.blue_in       <= b;
    in_ch.alpha_in      <= a;
    in_ch.channel_count <= ch;
    in_ch.covers_pixel  <= cov;
    in_ch.alpha_present <= ap;
    in_ch.last_layer    <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  // Random pixel: mostly 1..5 layers, sometimes a deep stack so transmittance
  // decays toward zero; a few layers carry a zero channel count
  task automatic send_random_pixel();
    int layers;
    logic [1:0] ch;
    layers = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 5);
    for (int k = 0; k < layers; k++) begin
      ch = 2'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : $urandom_range(1, 3));
      send_layer(draw_level(), draw_level(), draw_level(), draw_level(), ch,
                 $urandom_range(0, 4) != 0, $urandom_range(0, 3) != 0, k == layers - 1);
    end
  endtask

  // Result side: random stalls, plus two long hold-offs while the sender keeps
  // offering layers so the output register fills and in_ch backs up
  initial begin
    int stall;
    int taken;
    taken = 0;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (taken == 25 || taken == 160)
        stall = 300;
      else
        stall = draw_wait(recv_quiet);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      taken++;
    end
  end

  initial begin
    board = new();
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.red_in        <= '0;
    in_ch.green_in      <= '0;
    in_ch.blue_in       <= '0;
    in_ch.alpha_in      <= '0;
    in_ch.channel_count <= 2'd3;
    in_ch.covers_pixel  <= 1'b0;
    in_ch.alpha_present <= 1'b0;
    in_ch.last_layer    <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // opaque single layer, alpha missing, blue over range
    send_layer(UNITY, '0, '1, '0, 2'd3, 1'b1, 1'b0, 1'b1);
    // lone non-covering last layer: zeros out
    send_layer('1, '1, '1, '1, 2'd3, 1'b0, 1'b1, 1'b1);
    // one-channel half alpha, then two-channel opaque layer
    send_layer(17'h04000, 17'h1ffff, 17'h1ffff, 17'h08000, 2'd1, 1'b1, 1'b1, 1'b0);
    send_layer(17'h0c000, 17'h02000, 17'h1ffff, 17'h1ffff, 2'd2, 1'b1, 1'b0, 1'b1);
    // zero channel count with alpha over range
    send_layer(17'h0abcd, 17'h01234, 17'h05678, 17'h1ffff, 2'd0, 1'b1, 1'b1, 1'b1);
    // skipped middle layer carrying junk
    send_layer(17'h0ffff, 17'h08000, 17'h00001, 17'h04000, 2'd3, 1'b1, 1'b1, 1'b0);
    send_layer('1, '1, '1, '1, 2'd2, 1'b0, 1'b0, 1'b0);
    send_layer(UNITY, UNITY, UNITY, 17'h0ffff, 2'd3, 1'b1, 1'b1, 1'b1);
    // zero alpha is transparent, then full brightness behind it
    send_layer(UNITY, UNITY, UNITY, '0, 2'd3, 1'b1, 1'b1, 1'b0);
    send_layer(17'h15555, 17'h0aaaa, 17'h05555, UNITY, 2'd3, 1'b1, 1'b1, 1'b1);
    // all fields zero
    send_layer('0, '0, '0, '0, 2'd0, 1'b1, 1'b1, 1'b1);
    // everything at the top code
    send_layer('1, '1, '1, '1, 2'd3, 1'b1, 1'b1, 1'b1);
    // stack of near-opaque white layers: sums pile up toward 1.0
    for (int k = 0; k < 5; k++)
      send_layer(UNITY, 17'h0ffff, UNITY, 17'h0c000, 2'd3, 1'b1, 1'b1, k == 4);

    while (items_sent < ITEM_TARGET) send_random_pixel();
    in_ch.valid <= 1'b0;

    while (board.expected_pixels.size() != 0) @(posedge clk);
    // catch any stray late result
    repeat (20) @(posedge clk);
    if (board.errors == 0 && board.expected_pixels.size() == 0)
      $display("alpha_layer_compositor_top_tb passed");
    else
      $display("alpha_layer_compositor_top_tb failed");
    $finish;
  end

endmodule
